[rtl/core/median_filter_2d_assert.svh]
// assertion macros for the two-dimensional median filter
`ifndef MEDIAN_FILTER_2D_ASSERT_SVH
`define MEDIAN_FILTER_2D_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define MF2_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define MF2_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mf2_pkg.sv]
// shared constants, types and helpers of the median filter
package mf2_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned MAX_WINDOW = 7;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned WIN_CFG_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned SLOT_W = $clog2(MAX_WINDOW);
  localparam int unsigned HALF_W = $clog2(MAX_WINDOW / 2 + 1);
  localparam int unsigned LAG_W  =
    $clog2((MAX_WINDOW / 2) * MAX_WIDTH + MAX_WINDOW / 2 + 1);
  localparam int unsigned CELLS  = MAX_WINDOW * MAX_WINDOW;
  localparam int unsigned RANK_W = $clog2(CELLS + 1);

  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int unsigned OUT_DEPTH  = 16;
  localparam int unsigned OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int unsigned RES_W      = $clog2(OUT_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_WINDOW_SIZE  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_e;

  // one unit of work handed from the front to the back
  typedef struct packed {
    logic              pix;
    logic [PIX_W-1:0]  pixel;
    logic [COL_W-1:0]  in_col;
    logic [SLOT_W-1:0] in_slot;
    logic              emit;
    logic              border;
    logic              last;
    logic [COL_W-1:0]  out_col;
    logic [SLOT_W-1:0] out_slot;
  } cmd_t;

  // side data that travels with a window through the median stages
  typedef struct packed {
    logic             border;
    logic             last;
    logic [PIX_W-1:0] pass;
  } tag_t;

  typedef struct packed {
    logic in_done;
    logic out_done;
  } front_status_t;

  typedef struct packed {
    logic [RES_W-1:0] reserved;
  } back_status_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] res;
    if (slot == SLOT_W'(MAX_WINDOW - 1)) begin
      res = '0;
    end else begin
      res = slot + SLOT_W'(1);
    end
    return res;
  endfunction

endpackage

[rtl/core/mf2_stream_if.sv]
// valid/ready stream interfaces for pixel items in and filtered items out
interface mf2_in_if;
  import mf2_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [PIX_W-1:0] pixel_in;
  modport source (output valid, output req_type, output pixel_in, input ready);
  modport sink (input valid, input req_type, input pixel_in, output ready);
endinterface

interface mf2_out_if;
  import mf2_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_last;
  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

[rtl/core/median_filter_2d.sv]
// top level of the streaming two-dimensional median filter
// Streaming median filter for 8-bit grey frames in raster order. One item is
// taken per clock while the command queue has room: a pixel, or a drain tick
// that flushes an output still owed after the last pixel of the frame. The
// output stream lags the input by h rows and h columns (h = window side / 2);
// pixels within h of an edge come out unchanged, all others become the median
// of their window (side 1, 3, 5 or 7; even sizes are made odd). The last output
// of a frame has frame_last set. Throughput is one item per cycle while output
// room lasts, set by the line store: seven row banks of 1024 pixels, each
// written once and read at two columns per cycle. An item passes through the
// queue, line store read, window shift, eight radix-select median stages and
// output buffer. The line store is not cleared after reset. Any register write
// restarts the frame; write registers only while no item is in flight.
module median_filter_2d (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mf2_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mf2_pkg::CFG_W-1:0]      cfg_data_i,
  mf2_in_if.sink                         in_i,
  mf2_out_if.source                      out_o
);
  import mf2_pkg::*;

  // front to queue
  logic          fr_cmd_valid, fr_cmd_ready;
  cmd_t          fr_cmd;
  // queue to back
  logic          bk_cmd_valid, bk_cmd_ready;
  cmd_t          bk_cmd;
  // window half size follows the config registers
  logic [HALF_W-1:0] half;
  front_status_t fr_status;
  back_status_t  bk_status;

  // counters, config and classification of each item
  mf2_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_req_i    (in_i.req_type),
    .in_pixel_i  (in_i.pixel_in),
    .cmd_valid_o (fr_cmd_valid),
    .cmd_o       (fr_cmd),
    .cmd_ready_i (fr_cmd_ready),
    .half_o      (half),
    .status_o    (fr_status)
  );

  // lets the front run on while the back waits for output room
  mf2_cmd_queue u_cmd_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_cmd_valid),
    .push_ready_o (fr_cmd_ready),
    .push_i       (fr_cmd),
    .pop_valid_o  (bk_cmd_valid),
    .pop_ready_i  (bk_cmd_ready),
    .pop_o        (bk_cmd)
  );

  // line store, window, median and output buffer
  mf2_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (bk_cmd_valid),
    .cmd_ready_o (bk_cmd_ready),
    .cmd_i       (bk_cmd),
    .half_i      (half),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_pixel_o (out_o.pixel_out),
    .out_last_o  (out_o.frame_last),
    .status_o    (bk_status)
  );

`include "median_filter_2d_assert.svh"

  // the front only issues a command when the queue can take it
  `MF2_ASSERT_NOW(a_cmd_room, fr_cmd_valid, fr_cmd_ready, "command issued into a full queue")

  // reserved output slots never exceed the output buffer
  `MF2_ASSERT_NOW(a_credit_bound, 1'b1, bk_status.reserved <= RES_W'(OUT_DEPTH),
                  "output buffer overbooked")

  // issuing the last output of a frame closes the frame in the front
  `MF2_ASSERT_NEXT(a_last_closes, fr_cmd_valid && fr_cmd.emit && fr_cmd.last && !cfg_we_i,
                   fr_status.out_done && fr_status.in_done, "frame not closed after last item")

endmodule

[rtl/core/mf2_front.sv]
// front end: config registers, frame position counters, item classification
module mf2_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mf2_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mf2_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           in_req_i,
  input  logic [mf2_pkg::PIX_W-1:0]      in_pixel_i,
  output logic                           cmd_valid_o,
  output mf2_pkg::cmd_t                  cmd_o,
  input  logic                           cmd_ready_i,
  output logic [mf2_pkg::HALF_W-1:0]     half_o,
  output mf2_pkg::front_status_t         status_o
);
  import mf2_pkg::*;

  logic [CFG_W-1:0]     width_q, height_q;
  logic [WIN_CFG_W-1:0] win_q;
  logic [COL_W-1:0]     in_col_q, in_col_d;
  logic [ROW_W-1:0]     in_row_q, in_row_d;
  logic [SLOT_W-1:0]    in_slot_q, in_slot_d;
  logic [LAG_W-1:0]     fill_q, fill_d;
  logic [ROW_W-1:0]     out_row_q, out_row_d;
  logic [COL_W-1:0]     out_col_q, out_col_d;
  logic [SLOT_W-1:0]    out_slot_q, out_slot_d;

  logic [CFG_W-1:0]     w_eff, h_eff;
  logic [WIN_CFG_W-1:0] win_odd, win_eff;
  logic [HALF_W-1:0]    half;
  logic [LAG_W-1:0]     lag;
  logic [COL_W:0]       w_x;
  logic [ROW_W-1:0]     ht_r;
  logic                 in_done, out_done, fire, is_pix, restart, do_pix, emit;
  logic [COL_W-1:0]     cur_in_col, cur_out_col;
  logic [ROW_W-1:0]     cur_in_row, cur_out_row;
  logic [SLOT_W-1:0]    cur_in_slot, cur_out_slot;
  logic [LAG_W-1:0]     cur_fill;
  logic                 in_col_end, out_col_end, border, last;
  logic                 cfg_hit;

  always_comb begin
    w_eff = width_q;
    if (width_q == '0) w_eff = CFG_W'(1);
    else if (width_q > CFG_W'(MAX_WIDTH)) w_eff = CFG_W'(MAX_WIDTH);
    h_eff = height_q;
    if (height_q == '0) h_eff = CFG_W'(1);
    else if (height_q > CFG_W'(MAX_HEIGHT)) h_eff = CFG_W'(MAX_HEIGHT);
    win_odd = win_q | WIN_CFG_W'(1);
    win_eff = win_odd;
    if (int'(win_odd) > MAX_WINDOW) win_eff = WIN_CFG_W'((MAX_WINDOW - 1) | 1);
  end

  assign half = HALF_W'(win_eff >> 1);
  assign lag  = LAG_W'(LAG_W'(half) * LAG_W'(w_eff)) + LAG_W'(half);
  assign w_x  = (COL_W + 1)'(w_eff);
  assign ht_r = ROW_W'(h_eff);

  assign in_done  = in_row_q >= ht_r;
  assign out_done = out_row_q >= ht_r;

  assign in_ready_o = cmd_ready_i;
  assign fire       = in_valid_i & in_ready_o;
  assign is_pix     = (req_e'(in_req_i) == REQ_PIXEL);
  // a pixel after a fully delivered frame opens a new one
  assign restart    = is_pix & in_done & out_done;
  assign do_pix     = is_pix & (~in_done | out_done);

  assign cur_in_col   = restart ? '0 : in_col_q;
  assign cur_in_row   = restart ? '0 : in_row_q;
  assign cur_in_slot  = restart ? '0 : in_slot_q;
  assign cur_fill     = restart ? '0 : fill_q;
  assign cur_out_col  = restart ? '0 : out_col_q;
  assign cur_out_row  = restart ? '0 : out_row_q;
  assign cur_out_slot = restart ? '0 : out_slot_q;

  assign emit = is_pix ? (do_pix & (cur_fill >= lag)) : (in_done & ~out_done);

  assign in_col_end  = ({1'b0, cur_in_col} == w_x - (COL_W + 1)'(1));
  assign out_col_end = ({1'b0, cur_out_col} == w_x - (COL_W + 1)'(1));

  assign border = (cur_out_row < ROW_W'(half))
                | ((ROW_W + 1)'(cur_out_row) + (ROW_W + 1)'(half) >= (ROW_W + 1)'(ht_r))
                | (cur_out_col < COL_W'(half))
                | ((COL_W + 1)'(cur_out_col) + (COL_W + 1)'(half) >= w_x);
  assign last = (cur_out_row == ht_r - ROW_W'(1)) & out_col_end;

  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_slot_d  = in_slot_q;
    fill_d     = fill_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_slot_d = out_slot_q;
    if (fire & do_pix) begin
      in_col_d  = in_col_end ? '0 : cur_in_col + COL_W'(1);
      in_row_d  = in_col_end ? cur_in_row + ROW_W'(1) : cur_in_row;
      in_slot_d = in_col_end ? slot_inc(cur_in_slot) : cur_in_slot;
      fill_d    = (cur_fill >= lag) ? cur_fill : cur_fill + LAG_W'(1);
      out_col_d  = cur_out_col;
      out_row_d  = cur_out_row;
      out_slot_d = cur_out_slot;
    end
    if (fire & emit) begin
      out_col_d  = out_col_end ? '0 : cur_out_col + COL_W'(1);
      out_row_d  = out_col_end ? cur_out_row + ROW_W'(1) : cur_out_row;
      out_slot_d = out_col_end ? slot_inc(cur_out_slot) : cur_out_slot;
    end
  end

  always_comb begin
    cfg_hit = 1'b0;
    case (cfg_reg_e'(cfg_idx_i))
      REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_WINDOW_SIZE: cfg_hit = cfg_we_i;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= CFG_W'(640);
      height_q   <= CFG_W'(480);
      win_q      <= WIN_CFG_W'(3);
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      fill_q     <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
    end else if (cfg_hit) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        REG_WINDOW_SIZE:  win_q    <= cfg_data_i[WIN_CFG_W-1:0];
        default: ;
      endcase
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      fill_q     <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_slot_q  <= in_slot_d;
      fill_q     <= fill_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_slot_q <= out_slot_d;
    end
  end

  assign cmd_valid_o    = fire & (do_pix | emit);
  assign cmd_o.pix      = do_pix;
  assign cmd_o.pixel    = in_pixel_i;
  assign cmd_o.in_col   = cur_in_col;
  assign cmd_o.in_slot  = cur_in_slot;
  assign cmd_o.emit     = emit;
  assign cmd_o.border   = border;
  assign cmd_o.last     = last;
  assign cmd_o.out_col  = cur_out_col;
  assign cmd_o.out_slot = cur_out_slot;

  assign half_o            = half;
  assign status_o.in_done  = in_done;
  assign status_o.out_done = out_done;

endmodule

[rtl/core/mf2_cmd_queue.sv]
// short command queue between front and back
module mf2_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  mf2_pkg::cmd_t push_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output mf2_pkg::cmd_t pop_o
);
  import mf2_pkg::*;

  cmd_t                  mem_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_q, rd_q;
  logic [CMDQ_CNT_W-1:0] cnt_q;
  logic                  push, pop;

  assign push_ready_o = cnt_q != CMDQ_CNT_W'(CMDQ_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_o        = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + CMDQ_PTR_W'(1);
      if (pop) rd_q <= rd_q + CMDQ_PTR_W'(1);
      cnt_q <= cnt_q + CMDQ_CNT_W'(push) - CMDQ_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_i;
  end

endmodule

[rtl/core/mf2_median.sv]
// bitwise radix-select median, one result bit per pipeline stage
module mf2_median (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [mf2_pkg::PIX_W-1:0]   cells_i [mf2_pkg::CELLS],
  input  logic [mf2_pkg::HALF_W-1:0]  half_i,
  input  mf2_pkg::tag_t               tag_i,
  output logic                        valid_o,
  output logic [mf2_pkg::PIX_W-1:0]   median_o,
  output mf2_pkg::tag_t               tag_o
);
  import mf2_pkg::*;

  localparam int unsigned STAGES = PIX_W;

  logic [PIX_W-1:0]  cells_q [STAGES-1][CELLS];
  logic [CELLS-1:0]  cand_q [STAGES-1];
  logic [RANK_W-1:0] rank_q [STAGES-1];
  logic [PIX_W-1:0]  res_q [STAGES];
  tag_t              tag_q [STAGES];
  logic [STAGES-1:0] valid_q;

  logic [PIX_W-1:0]  src_cells [STAGES][CELLS];
  logic [CELLS-1:0]  src_cand [STAGES];
  logic [RANK_W-1:0] src_rank [STAGES];
  logic [PIX_W-1:0]  src_res [STAGES];
  tag_t              src_tag [STAGES];
  logic [STAGES-1:0] src_valid;
  logic [RANK_W-1:0] cnt [STAGES];
  logic [STAGES-1:0] take_zero;
  logic [CELLS-1:0]  nxt_cand [STAGES];
  logic [RANK_W-1:0] nxt_rank [STAGES];
  logic [PIX_W-1:0]  nxt_res [STAGES];

  logic [SLOT_W-1:0]   first;
  logic [HALF_W:0]     side;
  logic [2*HALF_W+1:0] side_sq;
  logic [CELLS-1:0]    mask;

  // only the side x side corner at the newest row and column of the window takes part
  assign first   = SLOT_W'(MAX_WINDOW - 1) - SLOT_W'({half_i, 1'b0});
  assign side    = {half_i, 1'b1};
  assign side_sq = (2*HALF_W+2)'(side) * (2*HALF_W+2)'(side);

  always_comb begin
    for (int j = 0; j < MAX_WINDOW; j++) begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
        mask[j*MAX_WINDOW+i] = (SLOT_W'(j) >= first) && (SLOT_W'(i) >= first);
      end
    end
  end

  always_comb begin
    src_cells[0] = cells_i;
    src_cand[0]  = mask;
    src_rank[0]  = RANK_W'(side_sq >> 1);
    src_res[0]   = '0;
    src_tag[0]   = tag_i;
    src_valid[0] = valid_i;
    for (int g = 1; g < STAGES; g++) begin
      src_cells[g] = cells_q[g-1];
      src_cand[g]  = cand_q[g-1];
      src_rank[g]  = rank_q[g-1];
      src_res[g]   = res_q[g-1];
      src_tag[g]   = tag_q[g-1];
      src_valid[g] = valid_q[g-1];
    end
  end

  // count candidates with a zero at this bit; the rank decides the side
  always_comb begin
    for (int g = 0; g < STAGES; g++) begin
      cnt[g] = '0;
      for (int c = 0; c < CELLS; c++) begin
        cnt[g] = cnt[g] + RANK_W'(src_cand[g][c] & ~src_cells[g][c][PIX_W-1-g]);
      end
      take_zero[g] = cnt[g] > src_rank[g];
      for (int c = 0; c < CELLS; c++) begin
        nxt_cand[g][c] = src_cand[g][c] &
                         (take_zero[g] ? ~src_cells[g][c][PIX_W-1-g]
                                       : src_cells[g][c][PIX_W-1-g]);
      end
      nxt_rank[g] = take_zero[g] ? src_rank[g] : src_rank[g] - cnt[g];
      nxt_res[g]  = src_res[g];
      nxt_res[g][PIX_W-1-g] = ~take_zero[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= src_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < STAGES; g++) begin
      res_q[g] <= nxt_res[g];
      tag_q[g] <= src_tag[g];
    end
    for (int g = 0; g < STAGES - 1; g++) begin
      cells_q[g] <= src_cells[g];
      cand_q[g]  <= nxt_cand[g];
      rank_q[g]  <= nxt_rank[g];
    end
  end

  assign valid_o  = valid_q[STAGES-1];
  assign median_o = res_q[STAGES-1];
  assign tag_o    = tag_q[STAGES-1];

endmodule

[rtl/core/mf2_back.sv]
// back end: line store, sliding window, median pipeline and output buffer
module mf2_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  mf2_pkg::cmd_t               cmd_i,
  input  logic [mf2_pkg::HALF_W-1:0]  half_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mf2_pkg::PIX_W-1:0]   out_pixel_o,
  output logic                        out_last_o,
  output mf2_pkg::back_status_t       status_o
);
  import mf2_pkg::*;

  localparam int unsigned N = MAX_WINDOW;

  logic [PIX_W-1:0] line_mem [N][MAX_WIDTH];
  logic [PIX_W-1:0] rda_q [N];
  logic [PIX_W-1:0] rdb_q [N];

  logic             a_valid_q;
  cmd_t             a_cmd_q;
  logic [PIX_W-1:0] win_q [N][N];
  logic [PIX_W-1:0] colv [N];
  logic             b_valid_q;
  tag_t             b_tag_q;
  logic [PIX_W-1:0] cells [CELLS];
  logic [SLOT_W:0]  rot [N];

  logic             med_valid;
  logic [PIX_W-1:0] med_value;
  tag_t             med_tag;

  logic [PIX_W:0]     ofifo_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] owr_q, ord_q;
  logic [RES_W-1:0]   ocnt_q, res_q;
  logic               pop, odeq;

  // room is reserved for every emitting command before it enters the pipe
  assign cmd_ready_o = res_q < RES_W'(OUT_DEPTH);
  assign pop         = cmd_valid_i & cmd_ready_o;

  always_ff @(posedge clk_i) begin
    if (pop & cmd_i.pix) line_mem[cmd_i.in_slot][cmd_i.in_col] <= cmd_i.pixel;
    for (int j = 0; j < N; j++) begin
      rda_q[j] <= line_mem[j][cmd_i.in_col];
      rdb_q[j] <= line_mem[j][cmd_i.out_col];
    end
  end

  always_ff @(posedge clk_i) begin
    a_cmd_q <= cmd_i;
  end

  // rows above the new pixel, oldest first, then the pixel itself
  always_comb begin
    for (int j = 0; j < N; j++) begin
      rot[j] = (SLOT_W + 1)'(a_cmd_q.in_slot) + (SLOT_W + 1)'(j + 1);
      if (rot[j] >= (SLOT_W + 1)'(N)) rot[j] = rot[j] - (SLOT_W + 1)'(N);
      colv[j] = rda_q[rot[j][SLOT_W-1:0]];
    end
    colv[N-1] = a_cmd_q.pixel;
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q & a_cmd_q.pix) begin
      for (int j = 0; j < N; j++) begin
        for (int i = 0; i < N - 1; i++) begin
          win_q[j][i] <= win_q[j][i+1];
        end
        win_q[j][N-1] <= colv[j];
      end
    end
    b_tag_q.border <= a_cmd_q.border;
    b_tag_q.last   <= a_cmd_q.last;
    b_tag_q.pass   <= rdb_q[a_cmd_q.out_slot];
  end

  always_comb begin
    for (int j = 0; j < N; j++) begin
      for (int i = 0; i < N; i++) begin
        cells[j*N+i] = win_q[j][i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= pop;
      b_valid_q <= a_valid_q & a_cmd_q.emit;
    end
  end

  mf2_median u_median (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (b_valid_q),
    .cells_i  (cells),
    .half_i   (half_i),
    .tag_i    (b_tag_q),
    .valid_o  (med_valid),
    .median_o (med_value),
    .tag_o    (med_tag)
  );

  assign out_valid_o = ocnt_q != '0;
  assign odeq        = out_valid_o & out_ready_i;
  assign out_pixel_o = ofifo_q[ord_q][PIX_W-1:0];
  assign out_last_o  = ofifo_q[ord_q][PIX_W];

  always_ff @(posedge clk_i) begin
    if (med_valid) begin
      ofifo_q[owr_q] <= {med_tag.last, med_tag.border ? med_tag.pass : med_value};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
      res_q  <= '0;
    end else begin
      if (med_valid) owr_q <= owr_q + OUT_PTR_W'(1);
      if (odeq) ord_q <= ord_q + OUT_PTR_W'(1);
      ocnt_q <= ocnt_q + RES_W'(med_valid) - RES_W'(odeq);
      res_q  <= res_q + RES_W'(pop & cmd_i.emit) - RES_W'(odeq);
    end
  end

  assign status_o.reserved = res_q;

endmodule
